// ===== sv/pcsg_pkg.sv =====
// shared types and constants for the pcm sample convert and gain block
package pcsg_pkg;

	// sample formats
	localparam logic [1:0] MODE_U8    = 2'd0;
	localparam logic [1:0] MODE_S16LE = 2'd1;
	localparam logic [1:0] MODE_S16BE = 2'd2;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_SAMPLE_MODE   = 3'd0,
		CFG_FLIP_SIGN     = 3'd1,
		CFG_GAIN_LEFT     = 3'd2,
		CFG_GAIN_RIGHT    = 3'd3,
		CFG_CHANNEL_COUNT = 3'd4
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 7;
	localparam int COUNT_W    = 6;
	localparam int POS_W      = 5;
	localparam int MAX_CHANNELS = 32;

	// reset values of the configuration registers
	localparam logic [1:0]         RST_MODE  = MODE_S16LE;
	localparam logic [GAIN_W-1:0]  RST_GAIN  = 7'd100;
	localparam logic [COUNT_W-1:0] RST_COUNT = 6'd2;

	// divide by 100 as multiply by ceil(2^30 / 100), exact for products below 2^23
	localparam int PROD_W  = SAMPLE_W + GAIN_W;
	localparam int RECIP_W = 24;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
	localparam int RECIP_SH = 30;
	localparam int QUOT_W   = 16;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	// back end stages holding an item
	localparam int BACK_STAGES = 3;
	localparam int PIPE_CAP    = QDEPTH + BACK_STAGES;

	// one classified sample on its way to the back end
	typedef struct packed {
		logic                is8;
		logic                big;
		logic                neg;
		logic [SAMPLE_W-1:0] mag;
		logic [GAIN_W-1:0]   gain;
	} entry_t;

	// queue status seen by the front end
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== sv/pcsg_in_if.sv =====
// input sample channel
interface pcsg_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample_bytes;
	logic        last_in_buffer;

	modport source (output valid, output sample_bytes, output last_in_buffer, input ready);
	modport sink (input valid, input sample_bytes, input last_in_buffer, output ready);
endinterface

// ===== sv/pcsg_out_if.sv =====
// output result channel
interface pcsg_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_bytes;

	modport source (output valid, output result_bytes, input ready);
	modport sink (input valid, input result_bytes, output ready);
endinterface

// ===== sv/pcm_sample_convert_and_gain.sv =====
// top level of the pcm sample convert and gain block
// path: a sample accepted is written to the queue, then goes through the multiply,
//   divide by 100 and clamp stages into the output register
// throughput: one sample per cycle unless the output stalls; the three-stage
//   multiply/divide/clamp back end and four-entry queue each move one item per cycle
// reset: arst_n clears config to defaults, channel position, queue and stage valids
module pcm_sample_convert_and_gain (
	input  logic                            clk,
	input  logic                            arst_n,
	pcsg_in_if.sink                         sample_in,
	pcsg_out_if.source                      result_out,
	input  logic                            wr_en,
	input  logic [pcsg_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pcsg_pkg::CFG_DATA_W-1:0] wr_data
);
	import pcsg_pkg::*;

	// front to queue
	logic    push;
	entry_t  push_data;
	// queue to back
	logic    pop;
	entry_t  head;
	q_stat_t q_stat;

	// front: holds config and channel position, turns each input transaction
	// into sign, magnitude, selected gain and format flags
	pcsg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (sample_in),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// queue: lets the front keep taking samples while the output is stalled
	pcsg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.q_stat    (q_stat)
	);

	// back: magnitude times gain, reciprocal divide by 100 (truncates toward
	// zero since it works on the magnitude), clamp and byte order restore
	pcsg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.result_out (result_out)
	);

endmodule

// ===== sv/pcsg_front.sv =====
// front end: config registers, channel tracking, gain select and sample decode
module pcsg_front (
	input  logic                            clk,
	input  logic                            arst_n,
	pcsg_in_if.sink                         sample_in,
	input  logic                            wr_en,
	input  logic [pcsg_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pcsg_pkg::CFG_DATA_W-1:0] wr_data,
	input  pcsg_pkg::q_stat_t               q_stat,
	output logic                            push,
	output pcsg_pkg::entry_t                push_data
);
	import pcsg_pkg::*;

	logic [1:0]         mode_q;
	logic               flip_q;
	logic [GAIN_W-1:0]  gain_l_q;
	logic [GAIN_W-1:0]  gain_r_q;
	logic [COUNT_W-1:0] count_q;
	logic [POS_W-1:0]   pos_q;

	logic [COUNT_W-1:0]  cnt_eff;
	logic [POS_W-1:0]    ch;
	logic [GAIN_W:0]     gain_sum;
	logic [GAIN_W-1:0]   gain_sel;
	logic [7:0]          b8;
	logic [7:0]          s8;
	logic [7:0]          mag8;
	logic [SAMPLE_W-1:0] raw;
	logic [SAMPLE_W-1:0] v16;
	logic [SAMPLE_W-1:0] mag16;
	logic [COUNT_W-1:0]  nxt;
	logic                is8;
	logic                big;

	assign sample_in.ready = !q_stat.full;
	assign push            = sample_in.valid && !q_stat.full;

	always_comb begin
		// clamp channel count to 1..MAX_CHANNELS
		if (count_q == '0) begin
			cnt_eff = COUNT_W'(1);
		end else if (count_q > COUNT_W'(MAX_CHANNELS)) begin
			cnt_eff = COUNT_W'(MAX_CHANNELS);
		end else begin
			cnt_eff = count_q;
		end
		// stale position after lowering the count counts as channel 0
		ch = ({1'b0, pos_q} < cnt_eff) ? pos_q : '0;

		gain_sum = {1'b0, gain_l_q} + {1'b0, gain_r_q};
		gain_sel = gain_sum[GAIN_W:1];
		if (cnt_eff >= COUNT_W'(2)) begin
			if (ch == POS_W'(0)) begin
				gain_sel = gain_l_q;
			end else if (ch == POS_W'(1)) begin
				gain_sel = gain_r_q;
			end
		end

		is8 = (mode_q == MODE_U8);
		big = (mode_q == MODE_S16BE);
		raw = sample_in.sample_bytes;

		// 8-bit: offset binary to signed
		b8   = raw[7:0] ^ {flip_q, 7'd0};
		s8   = {~b8[7], b8[6:0]};
		mag8 = s8[7] ? (8'd0 - s8) : s8;

		// 16-bit: put in native order, then sign and magnitude
		v16   = big ? {raw[7:0], raw[15:8]} : raw;
		v16   = v16 ^ {flip_q, 15'd0};
		mag16 = v16[15] ? (16'd0 - v16) : v16;

		push_data.is8  = is8;
		push_data.big  = big;
		push_data.neg  = is8 ? s8[7] : v16[15];
		push_data.mag  = is8 ? {8'd0, mag8} : mag16;
		push_data.gain = gain_sel;

		nxt = {1'b0, ch} + COUNT_W'(1);
		if (sample_in.last_in_buffer || nxt >= cnt_eff) begin
			nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= RST_MODE;
			flip_q   <= 1'b0;
			gain_l_q <= RST_GAIN;
			gain_r_q <= RST_GAIN;
			count_q  <= RST_COUNT;
			pos_q    <= '0;
		end else begin
			if (wr_en) begin
				unique case (cfg_idx_t'(wr_index))
					CFG_SAMPLE_MODE:   mode_q   <= wr_data[1:0];
					CFG_FLIP_SIGN:     flip_q   <= wr_data[0];
					CFG_GAIN_LEFT:     gain_l_q <= wr_data[GAIN_W-1:0];
					CFG_GAIN_RIGHT:    gain_r_q <= wr_data[GAIN_W-1:0];
					CFG_CHANNEL_COUNT: count_q  <= wr_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (push) begin
				pos_q <= nxt[POS_W-1:0];
			end
		end
	end

endmodule

// ===== sv/pcsg_queue.sv =====
// short fifo between front end and back end
module pcsg_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pcsg_pkg::entry_t  push_data,
	input  logic              pop,
	output pcsg_pkg::entry_t  pop_data,
	output pcsg_pkg::q_stat_t q_stat
);
	import pcsg_pkg::*;

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == QCW'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

endmodule

// ===== sv/pcsg_back.sv =====
// back end: gain multiply, divide by 100, clamp and byte formatting
module pcsg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pcsg_pkg::entry_t  head,
	input  pcsg_pkg::q_stat_t q_stat,
	output logic              pop,
	pcsg_out_if.source        result_out
);
	import pcsg_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic              is8_s1, big_s1, neg_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              is8_s2, big_s2, neg_s2;
	logic [QUOT_W-1:0] quot_s2;
	logic [SAMPLE_W-1:0] res_s3;

	logic [PROD_W+RECIP_W-1:0] recip_prod;
	logic [7:0]          byte8;
	logic [SAMPLE_W-1:0] word16;
	logic [SAMPLE_W-1:0] res_nxt;

	assign rdy_s3 = !v_s3 || result_out.ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign pop    = !q_stat.empty && rdy_s1;

	assign result_out.valid        = v_s3;
	assign result_out.result_bytes = res_s3;

	assign recip_prod = (PROD_W+RECIP_W)'(prod_s1) * (PROD_W+RECIP_W)'(RECIP_100);

	always_comb begin
		// 8-bit: signed result plus 128, clamped to 0..255
		if (neg_s2) begin
			byte8 = (quot_s2 > QUOT_W'(128)) ? 8'd0 : (8'd128 - quot_s2[7:0]);
		end else begin
			byte8 = (quot_s2 > QUOT_W'(127)) ? 8'd255 : (quot_s2[7:0] + 8'd128);
		end
		// 16-bit: clamp to signed range
		if (neg_s2) begin
			word16 = (quot_s2 > QUOT_W'(32768)) ? 16'h8000 : (16'd0 - quot_s2);
		end else begin
			word16 = (quot_s2 > QUOT_W'(32767)) ? 16'h7fff : quot_s2;
		end
		if (is8_s2) begin
			res_nxt = {8'd0, byte8};
		end else if (big_s2) begin
			res_nxt = {word16[7:0], word16[15:8]};
		end else begin
			res_nxt = word16;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			is8_s1  <= head.is8;
			big_s1  <= head.big;
			neg_s1  <= head.neg;
			prod_s1 <= PROD_W'(head.mag) * PROD_W'(head.gain);
		end
		if (v_s1 && rdy_s2) begin
			is8_s2  <= is8_s1;
			big_s2  <= big_s1;
			neg_s2  <= neg_s1;
			quot_s2 <= recip_prod[RECIP_SH+QUOT_W-1:RECIP_SH];
		end
		if (v_s2 && rdy_s3) begin
			res_s3 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= !q_stat.empty;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

endmodule

// ===== sv/pcsg_checker.sv =====
// port level checks for the pcm sample convert and gain block
module pcsg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_data
);
	import pcsg_pkg::*;

	logic [3:0] outst_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// transactions accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (in_acc && !out_acc) begin
			outst_q <= outst_q + 4'd1;
		end else if (out_acc && !in_acc) begin
			outst_q <= outst_q - 4'd1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outst_q != 4'd0)
		else $error("result without a pending sample");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q == 4'd0 |-> in_ready)
		else $error("input blocked while block is empty");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= 4'(PIPE_CAP))
		else $error("more samples in flight than storage");

endmodule

bind pcm_sample_convert_and_gain pcsg_checker u_pcsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_in.valid),
	.in_ready  (sample_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_data  (result_out.result_bytes)
);
